// File: hdl/mlbw_pkg.sv
// Shared types and constants for the multi-limb by word divider.
// Used by mlbw_ctrl, mlbw_dp and multi_limb_by_word_divider_top; depends on nothing.
package mlbw_pkg;

  localparam int LIMB_WIDTH = 64;
  localparam int CNT_W      = $clog2(LIMB_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LIMB_WIDTH - 1);

  // Start modes of a limb
  localparam logic [1:0] MODE_ZERO = 2'd0;  // divisor zero: no division
  localparam logic [1:0] MODE_PRE  = 2'd1;  // reduce running remainder first
  localparam logic [1:0] MODE_DIV  = 2'd2;  // divide straight away

  typedef struct packed {
    logic [63:0] dividend_limb;
    logic        is_last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] quotient_limb;
    logic [63:0] remainder;
    logic        last_out;
  } out_item_t;

  typedef struct packed {
    logic       load;         // take the input transaction
    logic [1:0] mode;
    logic       step;         // one restoring subtract step
    logic       switch_limb;  // reduction done, shift in the limb next
    logic       deliver;      // load the output register
  } dp_cmd_t;

  typedef struct packed {
    logic d_zero;     // masked divisor is zero
    logic hi_ge_d;    // running remainder not below divisor
    logic out_free;   // output register can take a result this cycle
  } dp_stat_t;

endpackage

// File: hdl/mlbw_dp.sv
// Datapath of the divider: divisor register, running remainder, shift-in
// register, quotient register and output register. Depends on mlbw_pkg.
module mlbw_dp import mlbw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_wr_en,
  input  logic [63:0] cfg_wr_data,
  input  in_item_t  in_data,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic [63:0]           divisor_r;
  logic [LIMB_WIDTH-1:0] rem_r, rem_nxt;
  logic [LIMB_WIDTH-1:0] sh_r, sh_nxt;
  logic [LIMB_WIDTH-1:0] limb_r, limb_nxt;
  logic [LIMB_WIDTH-1:0] q_r, q_nxt;
  logic                  last_r, last_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_r, out_nxt;

  logic [LIMB_WIDTH-1:0] d;
  logic [LIMB_WIDTH:0]   trial;
  logic                  take;

  assign d = divisor_r[LIMB_WIDTH-1:0];

  assign stat.d_zero   = (d == '0);
  assign stat.hi_ge_d  = (rem_r >= d);
  assign stat.out_free = !out_valid_r || !out_stall;

  // shifted remainder with next bit; carry out sits in the top bit
  assign trial = {rem_r, sh_r[LIMB_WIDTH-1]};
  assign take  = (trial >= {1'b0, d});

  always_comb begin
    rem_nxt       = rem_r;
    sh_nxt        = sh_r;
    limb_nxt      = limb_r;
    q_nxt         = q_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.load) begin
      limb_nxt = in_data.dividend_limb[LIMB_WIDTH-1:0];
      last_nxt = in_data.is_last;
      q_nxt    = '0;
      case (cmd.mode)
        MODE_ZERO: begin
          rem_nxt = '0;
        end
        MODE_PRE: begin
          sh_nxt  = rem_r;
          rem_nxt = '0;
        end
        MODE_DIV: begin
          sh_nxt = in_data.dividend_limb[LIMB_WIDTH-1:0];
        end
        default: begin
          rem_nxt = '0;
        end
      endcase
    end

    if (cmd.step) begin
      rem_nxt = take ? LIMB_WIDTH'(trial - {1'b0, d}) : trial[LIMB_WIDTH-1:0];
      q_nxt   = {q_r[LIMB_WIDTH-2:0], take};
      sh_nxt  = cmd.switch_limb ? limb_r : {sh_r[LIMB_WIDTH-2:0], 1'b0};
    end

    if (cmd.deliver) begin
      out_valid_nxt         = 1'b1;
      out_nxt.quotient_limb = 64'(q_r);
      out_nxt.remainder     = last_r ? 64'(rem_r) : 64'd0;
      out_nxt.last_out      = last_r;
      // drop the running remainder at the end of a number
      if (last_r) begin
        rem_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divisor_r   <= 64'd1;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        divisor_r <= cfg_wr_data;
      end
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r   <= sh_nxt;
    limb_r <= limb_nxt;
    q_r    <= q_nxt;
    last_r <= last_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: hdl/mlbw_ctrl.sv
// Controller of the divider: sequences load, reduction, division and delivery.
// Depends on mlbw_pkg; drives mlbw_dp through dp_cmd_t.
module mlbw_ctrl import mlbw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PRE  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    cmd             = '0;
    cmd.mode        = MODE_DIV;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          cnt_nxt  = CNT_LAST;
          if (stat.d_zero) begin
            cmd.mode  = MODE_ZERO;
            state_nxt = ST_DONE;
          end else if (stat.hi_ge_d) begin
            cmd.mode  = MODE_PRE;
            state_nxt = ST_PRE;
          end else begin
            cmd.mode  = MODE_DIV;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_PRE: begin
        cmd.step = 1'b1;
        if (cnt_r == '0) begin
          // old remainder reduced; now shift in the limb
          cmd.switch_limb = 1'b1;
          cnt_nxt         = CNT_LAST;
          state_nxt       = ST_DIV;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (stat.out_free) begin
          cmd.deliver = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_zero_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && stat.d_zero) |=> (state_r == ST_DONE))
    else $error("zero divisor did not skip the division");

  a_pre_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PRE && cnt_r == '0) |=> (state_r == ST_DIV && cnt_r == CNT_LAST))
    else $error("reduction pass did not hand over to division");

  a_div_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |=> (state_r == ST_DIV || state_r == ST_DONE))
    else $error("division left early");

  a_deliver_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.deliver |=> (state_r == ST_IDLE && !in_stall))
    else $error("controller not idle after delivery");

endmodule

// File: hdl/multi_limb_by_word_divider_top.sv
// Top level of the multi-limb by word divider.
// Instantiates mlbw_ctrl and mlbw_dp; depends on mlbw_pkg.
//
// Divides a number streamed as 64-bit limbs, most significant first, by the
// divisor in the configuration register (reset 1); each limb transaction
// gives one quotient limb, and the transaction marked last also gives the
// final remainder and clears the running remainder. A limb passes from
// acceptance to the result register through a load step, the
// one-bit-per-cycle restoring subtract loop and a delivery step. If the
// divisor was changed in the middle of a number and the running remainder is
// not below it, a further pass of the same loop reduces it first. A zero
// divisor gives zero fields and skips the loop. The next limb
// is accepted once the result is in the output register, even while it
// waits there; write the divisor only while no limb is in progress.
module multi_limb_by_word_divider_top import mlbw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mlbw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mlbw_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

// File: bench/tb_multi_limb_by_word_divider_top.sv
// Self-checking testbench for multi_limb_by_word_divider_top.
// Runs a directed table, then random multi-limb numbers against a 128-by-64 predictor.
// Depends on mlbw_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_multi_limb_by_word_divider_top;
  import mlbw_pkg::*;

  localparam int          RAND_ITEMS = 1800;
  localparam int          IDLE_LIMIT = 2000;
  localparam int          TAIL_WAIT  = 150;
  localparam logic [63:0] LIMB_MASK  = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - LIMB_WIDTH);
  localparam logic [63:0] ONES       = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic { ROW_CFG, ROW_LIMB } row_kind_t;

  typedef enum int { STALL_NONE, STALL_SPARSE, STALL_HOLDS, STALL_PERIODIC } stall_mode_t;

  typedef struct {
    row_kind_t   kind;
    logic [63:0] value;   // divisor for ROW_CFG, dividend limb for ROW_LIMB
    logic        last;
    bit          typed;   // expected fields given below instead of predicted
    logic [63:0] exp_q;
    logic [63:0] exp_r;
  } stim_row_t;

  localparam int N_ROWS = 25;

  stim_row_t directed_rows [N_ROWS] = '{
    // reset divisor is one: quotient equals the limb
    '{ROW_LIMB, 64'h0,                     1'b0, 1'b1, 64'h0,                     64'h0},
    '{ROW_LIMB, 64'hA5A5_5A5A_0F0F_F0F0,   1'b0, 1'b1, 64'hA5A5_5A5A_0F0F_F0F0,   64'h0},
    '{ROW_LIMB, ONES,                      1'b1, 1'b1, ONES,                      64'h0},
    // zero divisor gives zero fields
    '{ROW_CFG,  64'h0,                     1'b0, 1'b0, 64'h0,                     64'h0},
    '{ROW_LIMB, ONES,                      1'b0, 1'b1, 64'h0,                     64'h0},
    '{ROW_LIMB, 64'h5,                     1'b1, 1'b1, 64'h0,                     64'h0},
    // largest divisor
    '{ROW_CFG,  ONES,                      1'b0, 1'b0, 64'h0,                     64'h0},
    '{ROW_LIMB, ONES,                      1'b0, 1'b0, 64'h0,                     64'h0},
    '{ROW_LIMB, 64'hFFFF_FFFF_FFFF_FFFE,   1'b0, 1'b0, 64'h0,                     64'h0},
    '{ROW_LIMB, 64'h0,                     1'b1, 1'b0, 64'h0,                     64'h0},
    '{ROW_CFG,  64'h7,                     1'b0, 1'b0, 64'h0,                     64'h0},
    '{ROW_LIMB, 64'h123,                   1'b0, 1'b0, 64'h0,                     64'h0},
    '{ROW_LIMB, ONES,                      1'b1, 1'b0, 64'h0,                     64'h0},
    // top bit of the remainder set: carry out of the shift
    '{ROW_CFG,  64'h8000_0000_0000_0001,   1'b0, 1'b0, 64'h0,                     64'h0},
    '{ROW_LIMB, 64'h8000_0000_0000_0000,   1'b0, 1'b0, 64'h0,                     64'h0},
    '{ROW_LIMB, ONES,                      1'b0, 1'b0, 64'h0,                     64'h0},
    // smaller divisor in the middle of a number: remainder is reduced first
    '{ROW_CFG,  64'h3,                     1'b0, 1'b0, 64'h0,                     64'h0},
    '{ROW_LIMB, 64'hDEAD_BEEF,             1'b1, 1'b0, 64'h0,                     64'h0},
    // zero divisor in the middle of a number clears the running remainder
    '{ROW_CFG,  64'h5,                     1'b0, 1'b0, 64'h0,                     64'h0},
    '{ROW_LIMB, 64'h17,                    1'b0, 1'b0, 64'h0,                     64'h0},
    '{ROW_CFG,  64'h0,                     1'b0, 1'b0, 64'h0,                     64'h0},
    '{ROW_LIMB, 64'h9,                     1'b0, 1'b1, 64'h0,                     64'h0},
    '{ROW_CFG,  64'h5,                     1'b0, 1'b0, 64'h0,                     64'h0},
    '{ROW_LIMB, 64'h9,                     1'b1, 1'b0, 64'h0,                     64'h0},
    '{ROW_CFG,  64'h1,                     1'b0, 1'b0, 64'h0,                     64'h0}
  };

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [63:0] cfg_wr_data = '0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  in_item_t    in_data     = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  out_item_t   out_data;

  // predictor state
  logic [63:0] model_divisor = 64'h1;
  logic [63:0] model_run_rem = 64'h0;

  out_item_t   pending_results [$];
  int          mismatches  = 0;
  int          limbs_sent  = 0;
  int          idle_cycles = 0;

  stall_mode_t stall_mode = STALL_NONE;
  int          stall_hold = 0;
  int          stall_cyc  = 0;

  multi_limb_by_word_divider_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  always #2 clk = ~clk;

  // One limb step: reduce the carried remainder if needed, then divide (rem : limb).
  function automatic out_item_t divide_limb(input logic [63:0] limb, input logic last);
    logic [63:0]  d;
    logic [63:0]  hi;
    logic [127:0] num;
    logic [63:0]  q;
    logic [63:0]  r;
    out_item_t    res;
    d = model_divisor & LIMB_MASK;
    q = '0;
    r = '0;
    if (d != 0) begin
      hi = model_run_rem & LIMB_MASK;
      if (hi >= d) hi = hi % d;
      num = {hi, limb & LIMB_MASK};
      q = 64'(num / {64'd0, d});
      r = 64'(num % {64'd0, d});
    end
    res.quotient_limb = q;
    res.remainder     = last ? r : 64'h0;
    res.last_out      = last;
    model_run_rem     = last ? 64'h0 : r;
    return res;
  endfunction

  task automatic send_limb(input logic [63:0] limb, input logic last, input bit typed,
                           input logic [63:0] exp_q, input logic [63:0] exp_r);
    out_item_t res;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= '{dividend_limb: limb, is_last: last};
    do @(posedge clk); while (in_stall);
    res = divide_limb(limb, last);
    if (typed) begin
      res.quotient_limb = exp_q;
      res.remainder     = exp_r;
    end
    pending_results.push_back(res);
    limbs_sent++;
  endtask

  // Drop valid and wait until every outstanding transaction has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_divisor(input logic [63:0] value);
    drain();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    model_divisor = value;
  endtask

  // Receiver back-pressure, pattern chosen per phase.
  always @(negedge clk) begin
    stall_cyc <= stall_cyc + 1;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      case (stall_mode)
        STALL_NONE: begin
          out_stall <= 1'b0;
        end
        STALL_SPARSE: begin
          out_stall <= ($urandom_range(0, 3) == 0);
        end
        STALL_HOLDS: begin
          if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
          end else begin
            out_stall  <= ~out_stall;
            stall_hold <= out_stall ? $urandom_range(0, 40) : $urandom_range(0, 12);
          end
        end
        default: begin
          out_stall <= ((stall_cyc % 5) < 2);
        end
      endcase
    end
  end

  // Compare each returned transaction with the oldest expectation.
  always @(posedge clk) begin
    out_item_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result q=%h r=%h last=%b", $time,
                 out_data.quotient_limb, out_data.remainder, out_data.last_out);
        mismatches++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_data.quotient_limb !== exp_res.quotient_limb) begin
          $display("%0t: quotient_limb expected %h actual %h", $time,
                   exp_res.quotient_limb, out_data.quotient_limb);
          mismatches++;
        end
        if (out_data.remainder !== exp_res.remainder) begin
          $display("%0t: remainder expected %h actual %h", $time,
                   exp_res.remainder, out_data.remainder);
          mismatches++;
        end
        if (out_data.last_out !== exp_res.last_out) begin
          $display("%0t: last_out expected %b actual %b", $time,
                   exp_res.last_out, out_data.last_out);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: no transaction on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [63:0] limb;
    logic [63:0] div_val;
    int          limbs_left;
    int          phase_len;
    int          burst_left;
    int          gap;
    bit          sender_idles;
    limbs_left = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_divisor(directed_rows[i].value);
      end else begin
        send_limb(directed_rows[i].value, directed_rows[i].last, directed_rows[i].typed,
                  directed_rows[i].exp_q, directed_rows[i].exp_r);
      end
    end

    limbs_sent = 0;
    while (limbs_sent < RAND_ITEMS) begin
      // a phase may end in the middle of a number, so the divisor also changes mid-number
      case ($urandom_range(0, 7))
        0:       div_val = ($urandom_range(0, 3) == 0) ? 64'h0 : 64'h1;
        1:       div_val = ONES;
        2:       div_val = 64'($urandom_range(2, 1000));
        3:       div_val = 64'h1 << $urandom_range(0, 63);
        4:       div_val = {1'b1, 31'($urandom), $urandom};
        default: div_val = {$urandom, $urandom};
      endcase
      write_divisor(div_val);
      stall_mode   = stall_mode_t'($urandom_range(0, 3));
      sender_idles = ($urandom_range(0, 3) != 0);
      phase_len    = $urandom_range(10, 60);
      burst_left   = $urandom_range(1, 8);
      repeat (phase_len) begin
        if (limbs_left == 0) begin
          limbs_left = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20)
                                                    : $urandom_range(1, 6);
        end
        case ($urandom_range(0, 7))
          0:       limb = 64'h0;
          1:       limb = ONES;
          default: limb = {$urandom, $urandom};
        endcase
        send_limb(limb, limbs_left == 1, 1'b0, 64'h0, 64'h0);
        limbs_left--;
        if (sender_idles) begin
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap        = $urandom_range(1, 90);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
          end
        end
      end
    end

    drain();
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/mlbw_pkg.sv
hdl/mlbw_dp.sv
hdl/mlbw_ctrl.sv
hdl/multi_limb_by_word_divider_top.sv
bench/tb_multi_limb_by_word_divider_top.sv
